### hw/rtl/text_console_writer_core_defines.svh
// Assertion macros for the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TCW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define TCW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Character codes and colours
  localparam logic [7:0]  NEWLINE_CODE     = 8'd10;
  localparam logic [7:0]  BLANK_CODE       = 8'd32;
  localparam logic [7:0]  TEXT_COLOR_RESET = 8'd7;
  localparam logic [15:0] RESET_CELL       = {TEXT_COLOR_RESET, BLANK_CODE};

  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } state_t;

  // One input word
  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } item_t;

  // One result word
  typedef struct packed {
    logic [15:0] cell_entry;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } result_t;

endpackage

### hw/rtl/tcw_screen_ram.sv
// Screen cell store: one write port, one read port with registered data.
module tcw_screen_ram import tcw_pkg::*; #(
  parameter int DEPTH = ROWS_DEF * COLUMNS_DEF,
  parameter int AW    = $clog2(ROWS_DEF * COLUMNS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tcw_ctrl.sv
// Sequencer: cursor, circular row offset, clearing pass, scroll blanking, reads.
`include "text_console_writer_core_defines.svh"

module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_color,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RowW  = $clog2(ROWS);
  localparam int ColW  = $clog2(COLUMNS);
  localparam int AddrW = $clog2(CELLS);

  state_t            state, state_next;
  logic [RowW-1:0]   row_pos, row_next;
  logic [ColW-1:0]   col_pos, col_next;
  logic [RowW-1:0]   top_row, top_next;   // physical row shown as logical row 0
  logic [AddrW-1:0]  clear_cnt, clear_next;
  logic [ColW-1:0]   scroll_cnt, scroll_next;
  logic              rd_hit, rd_hit_next;
  result_t           res_next;

  logic              adv, scr;
  logic [ColW:0]     col_inc;
  logic              last_row;
  logic              rd_ok;
  logic [RowW-1:0]   sel_lrow;
  logic [ColW-1:0]   sel_col;
  logic [RowW:0]     row_sum;
  logic [RowW-1:0]   phys_row;
  logic [AddrW-1:0]  cell_addr;

  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_waddr;
  logic [15:0]       mem_wdata, mem_rdata;

  // logical to physical row, then cell address
  always_comb begin
    row_sum   = (RowW+1)'(sel_lrow) + (RowW+1)'(top_row);
    phys_row  = (row_sum >= (RowW+1)'(ROWS)) ? RowW'(row_sum - (RowW+1)'(ROWS))
                                              : RowW'(row_sum);
    cell_addr = AddrW'(phys_row) * AddrW'(COLUMNS) + AddrW'(sel_col);
  end

  assign col_inc  = (ColW+1)'(col_pos) + (ColW+1)'(1);
  assign last_row = (row_pos == RowW'(ROWS - 1));
  assign rd_ok    = ({2'b00, item.read_row} < 7'(ROWS)) &&
                    ({2'b00, item.read_col} < 9'(COLUMNS));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      row_pos    <= '0;
      col_pos    <= '0;
      top_row    <= '0;
      clear_cnt  <= '0;
      scroll_cnt <= '0;
      rd_hit     <= 1'b0;
    end else begin
      state      <= state_next;
      row_pos    <= row_next;
      col_pos    <= col_next;
      top_row    <= top_next;
      clear_cnt  <= clear_next;
      scroll_cnt <= scroll_next;
      rd_hit     <= rd_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // next state, memory strobes
  always_comb begin
    state_next  = state;
    row_next    = row_pos;
    col_next    = col_pos;
    top_next    = top_row;
    clear_next  = clear_cnt;
    scroll_next = scroll_cnt;
    rd_hit_next = rd_hit;
    res_next    = res;
    item_ready  = 1'b0;
    res_valid   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = cell_addr;
    mem_wdata   = {text_color, item.char_code};
    sel_lrow    = row_pos;
    sel_col     = col_pos;
    adv         = 1'b0;
    scr         = 1'b0;

    unique case (state)
      // fill every cell with the reset blank
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_cnt;
        mem_wdata = RESET_CELL;
        if (clear_cnt == AddrW'(CELLS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clear_next = clear_cnt + AddrW'(1);
        end
      end

      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item.op == OP_READ) begin
            sel_lrow    = RowW'(item.read_row);
            sel_col     = ColW'(item.read_col);
            mem_re      = rd_ok;
            rd_hit_next = rd_ok;
            state_next  = ST_READ;
          end else begin
            if (item.char_code == NEWLINE_CODE) begin
              adv = 1'b1;
            end else begin
              mem_we = 1'b1;
              if (col_inc == (ColW+1)'(COLUMNS)) begin
                adv = 1'b1;
              end else begin
                col_next = ColW'(col_inc);
              end
            end
            state_next = ST_DONE;
            if (adv) begin
              col_next = '0;
              if (last_row) begin
                scr         = 1'b1;
                scroll_next = '0;
                state_next  = ST_SCROLL;
              end else begin
                row_next = row_pos + RowW'(1);
              end
            end
          end
          res_next.cell_entry = '0;
          res_next.cursor_row = 5'(row_next);
          res_next.cursor_col = 7'(col_next);
          res_next.scrolled   = scr;
        end
      end

      ST_READ: begin
        res_next.cell_entry = rd_hit ? mem_rdata : 16'h0000;
        state_next          = ST_DONE;
      end

      // blank the old top row, which becomes the new bottom row
      ST_SCROLL: begin
        mem_we    = 1'b1;
        sel_lrow  = '0;
        sel_col   = scroll_cnt;
        mem_wdata = {text_color, BLANK_CODE};
        if (scroll_cnt == ColW'(COLUMNS - 1)) begin
          top_next   = (top_row == RowW'(ROWS - 1)) ? '0 : top_row + RowW'(1);
          state_next = ST_DONE;
        end else begin
          scroll_next = scroll_cnt + ColW'(1);
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AddrW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cell_addr),
    .rdata (mem_rdata)
  );

  // cursor and row offset stay on the screen
  `TCW_ASSERT_IMP(a_pos_range, clk, rst, 1'b1, (int'(col_pos) < COLUMNS) && (int'(row_pos) < ROWS) && (int'(top_row) < ROWS), "cursor or row offset off screen")
  // row blanking finishes with a scrolled result
  `TCW_ASSERT_NXT(a_scroll_done, clk, rst, (state == ST_SCROLL) && (scroll_cnt == ColW'(COLUMNS - 1)), (state == ST_DONE) && res.scrolled, "scroll did not complete")
  // a read leaves the cursor alone
  `TCW_ASSERT_NXT(a_read_keeps_cursor, clk, rst, (state == ST_IDLE) && item_valid && (item.op == OP_READ), $stable(row_pos) && $stable(col_pos), "read moved the cursor")

endmodule

### hw/rtl/text_console_writer_core.sv
// Text console writer: put characters on a scrolling text screen, read back cells. A put or a
// newline goes from acceptance to ST_DONE and then into the output register; with that
// register free, the next word is taken on the return to ST_IDLE. A read also passes through
// ST_READ, for the registered memory read. A put or newline that leaves the last row also
// passes through ST_SCROLL to blank the COLUMNS cells (80 by default) of the new bottom row,
// since the screen is kept as a ring of rows in one single-port-write memory and a scroll
// only moves the ring offset. The block takes one word at a time and accepts the next while a
// result waits in the output register. After reset every cell is written with a grey blank,
// one cell a cycle, ROWS*COLUMNS cells (2000 by default); s_axis_tready stays low during that
// pass, colour writes are taken at any time.
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // colour register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // text_color
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic        s_axis_tuser,   // op
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // cell_entry[15:0], cursor_row[20:16],
                                      // cursor_col[27:21], scrolled[28]
);

  logic [7:0] text_color;
  item_t      item;
  result_t    res;
  logic       res_valid, res_ready;

  // colour register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
    end else if (cfg_valid) begin
      text_color <= cfg_data;
    end
  end

  // unpack input word
  assign item.op        = op_t'(s_axis_tuser);
  assign item.char_code = s_axis_tdata[7:0];
  assign item.read_row  = s_axis_tdata[12:8];
  assign item.read_col  = s_axis_tdata[19:13];

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .item_valid (s_axis_tvalid),
    .item_ready (s_axis_tready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {3'b000, res.scrolled, res.cursor_col, res.cursor_row, res.cell_entry};
    end
  end

endmodule

### verif/text_console_writer_core_tb.sv
// Self-checking testbench for the text console writer: directed table, then random words.
module text_console_writer_core_tb;
  import tcw_pkg::*;

  localparam int COLS       = COLUMNS_DEF;
  localparam int ROWS       = ROWS_DEF;
  localparam int CELLS      = COLS * ROWS;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_LEN   = 400;
  localparam int DRAIN_WAIT = 100;
  localparam int PHASE_LEN  = 480;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // char_code[7:0], read_row[12:8], read_col[19:13]
  logic        s_axis_tuser = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // cell_entry[15:0], cursor_row[20:16],
                                    // cursor_col[27:21], scrolled[28]

  text_console_writer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock, period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Console shadow: screen, cursor and colour
  logic [15:0] screen_shadow [0:CELLS-1];
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;
  logic [7:0]  colour_shadow = TEXT_COLOR_RESET;

  result_t     console_results_q [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          cycle_cnt = 0;
  bit          long_lines = 1'b0;

  typedef struct {
    op_t        op;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    int         reps;
    bit         typed;
    result_t    want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // Cursor to start of next row; scroll when leaving the last row
  function automatic logic next_row();
    cur_col = 0;
    if (cur_row + 1 < ROWS) begin
      cur_row++;
      return 1'b0;
    end
    for (int i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) screen_shadow[i] = {colour_shadow, BLANK_CODE};
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  // Result of one word, updating the shadow
  function automatic result_t console_step(op_t op, logic [7:0] ch, logic [4:0] rr,
                                           logic [6:0] rc);
    result_t res;
    res = '0;
    if (op == OP_READ) begin
      if (rr < ROWS && rc < COLS) res.cell_entry = screen_shadow[rr * COLS + rc];
    end else if (ch == NEWLINE_CODE) begin
      res.scrolled = next_row();
    end else begin
      screen_shadow[cur_row * COLS + cur_col] = {colour_shadow, ch};
      cur_col++;
      if (cur_col >= COLS) res.scrolled = next_row();
    end
    res.cursor_row = cur_row[4:0];
    res.cursor_col = cur_col[6:0];
    return res;
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    mismatches++;
  endtask

  // Offer one input word with random gaps; predict once it is taken
  task automatic offer_word(op_t op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc,
                            bit typed = 1'b0, result_t want = '0);
    result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, rc, rr, ch};
    do @(posedge clk); while (!s_axis_tready);
    pred = console_step(op, ch, rr, rc);
    console_results_q.push_back(typed ? want : pred);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (console_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_colour(logic [7:0] colour);
    cfg_valid <= 1'b1;
    cfg_data  <= colour;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    colour_shadow = colour;
  endtask

  task automatic add_row(op_t op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc,
                         int reps, bit typed, result_t want);
    dir_rows.push_back('{op, ch, rr, rc, reps, typed, want});
  endtask

  // Random text: short or long lines, reads mostly in range
  task automatic send_text(int n);
    op_t        op;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 59) == 0) long_lines = ~long_lines;
      ch = 8'($urandom_range(0, 255));
      rr = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(0, ROWS - 1));
      rc = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(0, COLS - 1));
      if ($urandom_range(0, 99) < 25) begin
        op = OP_READ;
      end else begin
        op = OP_PUT;
        if ($urandom_range(0, long_lines ? 149 : 7) == 0) ch = NEWLINE_CODE;
      end
      offer_word(op, ch, rr, rc);
    end
  endtask

  // Result side: check taken words, then choose next tready
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (console_results_q.size() == 0) begin
        flag_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = console_results_q.pop_front();
        if (m_axis_tdata[15:0] != want.cell_entry)
          flag_mismatch("cell_entry", int'(m_axis_tdata[15:0]), int'(want.cell_entry));
        if (m_axis_tdata[20:16] != want.cursor_row)
          flag_mismatch("cursor_row", int'(m_axis_tdata[20:16]), int'(want.cursor_row));
        if (m_axis_tdata[27:21] != want.cursor_col)
          flag_mismatch("cursor_col", int'(m_axis_tdata[27:21]), int'(want.cursor_col));
        if (m_axis_tdata[28] != want.scrolled)
          flag_mismatch("scrolled", int'(m_axis_tdata[28]), int'(want.scrolled));
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("text_console_writer_core test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) screen_shadow[i] = RESET_CELL;

    // Directed: reset contents, range limits, newline and wrap on the last row
    add_row(OP_READ, 8'h00, 5'd0,  7'd0,   1, 1'b1, {16'h0720, 5'd0, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd24, 7'd79,  1, 1'b1, {16'h0720, 5'd0, 7'd0, 1'b0});
    add_row(OP_READ, 8'hFF, 5'd25, 7'd0,   1, 1'b1, {16'h0000, 5'd0, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd31, 7'd127, 1, 1'b1, {16'h0000, 5'd0, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd0,  7'd80,  1, 1'b1, {16'h0000, 5'd0, 7'd0, 1'b0});
    add_row(OP_PUT,  8'h41, 5'd31, 7'd127, 1, 1'b1, {16'h0000, 5'd0, 7'd1, 1'b0});
    add_row(OP_PUT,  8'hFF, 5'd0,  7'd0,   1, 1'b1, {16'h0000, 5'd0, 7'd2, 1'b0});
    add_row(OP_PUT,  8'h00, 5'd0,  7'd0,   1, 1'b1, {16'h0000, 5'd0, 7'd3, 1'b0});
    add_row(OP_READ, 8'h00, 5'd0,  7'd0,   1, 1'b1, {16'h0741, 5'd0, 7'd3, 1'b0});
    add_row(OP_READ, 8'h00, 5'd0,  7'd1,   1, 1'b1, {16'h07FF, 5'd0, 7'd3, 1'b0});
    add_row(OP_READ, 8'h00, 5'd0,  7'd2,   1, 1'b1, {16'h0700, 5'd0, 7'd3, 1'b0});
    add_row(OP_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 1, 1'b1, {16'h0000, 5'd1, 7'd0, 1'b0});
    // wrap mid-screen, then down to the last row
    add_row(OP_PUT,  8'h5A, 5'd0,  7'd0,  85, 1'b0, '0);
    add_row(OP_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 22, 1'b0, '0);
    add_row(OP_PUT,  NEWLINE_CODE, 5'd0, 7'd0, 1, 1'b1, {16'h0000, 5'd24, 7'd0, 1'b1});
    add_row(OP_READ, 8'h00, 5'd24, 7'd0,   1, 1'b1, {16'h0720, 5'd24, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd0,  7'd0,   1, 1'b0, '0);
    add_row(OP_PUT,  8'h78, 5'd0,  7'd0,  79, 1'b0, '0);
    add_row(OP_PUT,  8'h79, 5'd0,  7'd0,   1, 1'b1, {16'h0000, 5'd24, 7'd0, 1'b1});
    add_row(OP_READ, 8'h00, 5'd23, 7'd79,  1, 1'b1, {16'h0779, 5'd24, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd23, 7'd0,   1, 1'b1, {16'h0778, 5'd24, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd24, 7'd79,  1, 1'b1, {16'h0720, 5'd24, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd0,  7'd127, 1, 1'b1, {16'h0000, 5'd24, 7'd0, 1'b0});
    add_row(OP_READ, 8'h00, 5'd31, 7'd0,   1, 1'b1, {16'h0000, 5'd24, 7'd0, 1'b0});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++)
        offer_word(dir_rows[r].op, dir_rows[r].ch, dir_rows[r].rr, dir_rows[r].rc,
                   dir_rows[r].typed, dir_rows[r].want);
    end
    drain();

    // Full rate both sides, white on white
    write_colour(8'hFF);
    send_text(PHASE_LEN);
    drain();

    // Idle sender, then a long receiver hold-off while words keep coming
    write_colour(8'h00);
    send_idle_pct = 63;
    send_text(PHASE_LEN);
    send_idle_pct = 0;
    hold_reqs++;
    send_text(48);
    drain();

    // Stalling receiver
    write_colour(8'($urandom_range(0, 255)));
    stall_pct = 63;
    send_text(PHASE_LEN);
    drain();

    // Both sides idle now and then
    write_colour(8'h1E);
    send_idle_pct = 21;
    stall_pct = 21;
    send_text(PHASE_LEN);
    drain();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("text_console_writer_core test passed");
    else
      $display("text_console_writer_core test failed");
    $finish;
  end

endmodule
